// ===== hw/rtl/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

  localparam int POOL_BYTES_DEF = 65536;
  localparam int SLOT_COUNT_DEF = 32;
  localparam int ALIGN_LOG2     = 3;
  localparam int ALIGN_BYTES    = 1 << ALIGN_LOG2;
  localparam int MAX_OWNERS     = 16;

  localparam int KIND_W     = 2;
  localparam int REQ_W      = 17;
  localparam int BOFF_W     = 16;
  localparam int OWNER_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int RES_OFF_W  = 16;
  localparam int RES_SIZE_W = 17;
  localparam int MS_W       = 17;

  localparam logic [MS_W-1:0] MIN_SPLIT_RST = MS_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_FREE     = 2'd1,
    KIND_FREE_ALL = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_CHK,
    S_TAIL,
    S_GRANT,
    S_RELEASE,
    S_DONE
  } state_t;

  // owner number folded into the owner range
  function automatic logic [OWNER_W-1:0] owner_fold(input logic [OWNER_W-1:0] v);
    logic [OWNER_W-1:0] r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      if (int'(r) >= MAX_OWNERS) begin
        r = r - OWNER_W'(MAX_OWNERS);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfa_table.sv =====
`default_nettype none

module bfa_table #(
  parameter int DEPTH = 32,
  parameter int ENT_W = 38
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [ENT_W-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [ENT_W-1:0]         rd_data
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_ctrl.sv =====
`default_nettype none

module bfa_ctrl #(
  parameter int POOL_BYTES = 65536,
  parameter int SLOT_COUNT = 32,
  parameter int ENT_W      = 38
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [bfa_pkg::MS_W-1:0]            min_split,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [bfa_pkg::KIND_W-1:0]          in_kind,
  input  wire logic [bfa_pkg::REQ_W-1:0]           in_request_size,
  input  wire logic [bfa_pkg::BOFF_W-1:0]          in_block_offset,
  input  wire logic [bfa_pkg::OWNER_W-1:0]         in_owner,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [bfa_pkg::STATUS_W-1:0]             out_status,
  output logic [bfa_pkg::RES_OFF_W-1:0]            out_offset,
  output logic [bfa_pkg::RES_SIZE_W-1:0]           out_block_size,
  output logic [bfa_pkg::RES_SIZE_W-1:0]           out_free_left,
  output logic                                     tbl_wr_en,
  output logic [$clog2(SLOT_COUNT)-1:0]            tbl_wr_addr,
  output logic [ENT_W-1:0]                         tbl_wr_data,
  output logic [$clog2(SLOT_COUNT)-1:0]            tbl_rd_addr,
  input  wire logic [ENT_W-1:0]                    tbl_rd_data
);

  import bfa_pkg::*;

  localparam int SZ_W   = $clog2(POOL_BYTES + 1);
  localparam int OFF_W  = $clog2(POOL_BYTES);
  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int NEED_W = REQ_W + 1;
  localparam int CW     = (SZ_W > NEED_W) ? SZ_W : NEED_W;
  localparam int SW     = ((CW > MS_W) ? CW : MS_W) + 1;
  localparam int TOW    = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
  localparam int OW     = (OFF_W > BOFF_W) ? OFF_W : BOFF_W;

  state_t state_r, state_nxt;

  kind_t               kind_r, kind_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [BOFF_W-1:0]   boff_r, boff_nxt;
  logic [OWNER_W-1:0]  own_r, own_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SZ_W-1:0]     free_r, free_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [SZ_W-1:0]     best_size_r, best_size_nxt;
  logic [OFF_W-1:0]    best_off_r, best_off_nxt;
  logic [OWNER_W-1:0]  best_own_r, best_own_nxt;
  logic                split_r, split_nxt;
  logic [SZ_W-1:0]     acc_r, acc_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic [SZ_W-1:0]     res_size_r, res_size_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [RES_OFF_W-1:0]  out_offset_r, out_offset_nxt;
  logic [RES_SIZE_W-1:0] out_size_r, out_size_nxt;
  logic [RES_SIZE_W-1:0] out_free_r, out_free_nxt;

  logic [OFF_W-1:0]   e_off;
  logic [SZ_W-1:0]    e_size;
  logic [OWNER_W-1:0] e_own;
  logic               e_used;

  logic [NEED_W-1:0] in_need;
  logic [SW-1:0]     split_sum;
  logic [CW-1:0]     tail_size_dif;
  logic [TOW-1:0]    tail_off_sum;
  logic [SZ_W-1:0]   grant_size;
  logic              in_fire;

  assign e_off  = tbl_rd_data[OFF_W-1:0];
  assign e_size = tbl_rd_data[OFF_W +: SZ_W];
  assign e_own  = tbl_rd_data[OFF_W+SZ_W +: OWNER_W];
  assign e_used = tbl_rd_data[ENT_W-1];

  // round up to the alignment
  assign in_need = (NEED_W'(in_request_size) + NEED_W'(ALIGN_BYTES - 1))
                   & ~NEED_W'(ALIGN_BYTES - 1);

  assign split_sum     = SW'(need_r) + SW'(min_split);
  assign tail_size_dif = CW'(best_size_r) - CW'(need_r);
  assign tail_off_sum  = TOW'(best_off_r) + TOW'(need_r);
  assign grant_size    = split_r ? SZ_W'(need_r) : best_size_r;

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign tbl_rd_addr = iss_r[IDX_W-1:0];

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_offset     = out_offset_r;
  assign out_block_size = out_size_r;
  assign out_free_left  = out_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= CNT_W'(1);
      free_r      <= SZ_W'(POOL_BYTES);
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    need_r       <= need_nxt;
    boff_r       <= boff_nxt;
    own_r        <= own_nxt;
    iss_r        <= iss_nxt;
    chk_idx_r    <= chk_idx_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_size_r  <= best_size_nxt;
    best_off_r   <= best_off_nxt;
    best_own_r   <= best_own_nxt;
    split_r      <= split_nxt;
    acc_r        <= acc_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_size_r   <= res_size_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_size_r   <= out_size_nxt;
    out_free_r   <= out_free_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    need_nxt       = need_r;
    boff_nxt       = boff_r;
    own_nxt        = own_r;
    cnt_nxt        = cnt_r;
    free_nxt       = free_r;
    iss_nxt        = iss_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_size_nxt  = best_size_r;
    best_off_nxt   = best_off_r;
    best_own_nxt   = best_own_r;
    split_nxt      = split_r;
    acc_nxt        = acc_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_size_nxt   = out_size_r;
    out_free_nxt   = out_free_r;
    tbl_wr_en      = 1'b0;
    tbl_wr_addr    = chk_idx_r;
    tbl_wr_data    = tbl_rd_data;

    unique case (state_r)
      S_INIT: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = '0;
        tbl_wr_data = {1'b0, OWNER_W'(0), SZ_W'(POOL_BYTES), OFF_W'(0)};
        state_nxt   = S_IDLE;
      end

      S_IDLE: begin
        if (in_fire) begin
          kind_nxt       = kind_t'(in_kind);
          need_nxt       = in_need;
          boff_nxt       = in_block_offset;
          own_nxt        = owner_fold(in_owner);
          iss_nxt        = '0;
          found_nxt      = 1'b0;
          acc_nxt        = '0;
          res_status_nxt = ST_OK;
          res_off_nxt    = '0;
          res_size_nxt   = '0;
          if (kind_t'(in_kind) == KIND_NONE) begin
            state_nxt = S_DONE;
          end else if (kind_t'(in_kind) == KIND_ALLOC && in_request_size == '0) begin
            res_status_nxt = ST_ZERO;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (iss_r < cnt_r) begin
          iss_nxt     = iss_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[IDX_W-1:0];
        end
        if (chk_vld_r) begin
          unique case (kind_r)
            KIND_ALLOC: begin
              if (!e_used && CW'(e_size) >= CW'(need_r) &&
                  (!found_r || e_size < best_size_r)) begin
                found_nxt     = 1'b1;
                best_idx_nxt  = chk_idx_r;
                best_size_nxt = e_size;
                best_off_nxt  = e_off;
              end
            end
            KIND_FREE: begin
              if (!found_r && e_used && OW'(e_off) == OW'(boff_r)) begin
                found_nxt     = 1'b1;
                best_idx_nxt  = chk_idx_r;
                best_size_nxt = e_size;
                best_off_nxt  = e_off;
                best_own_nxt  = e_own;
              end
            end
            KIND_FREE_ALL: begin
              if (e_used && e_own == own_r) begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = chk_idx_r;
                tbl_wr_data = {1'b0, e_own, e_size, e_off};
                acc_nxt     = acc_r + e_size;
                free_nxt    = free_r + e_size;
              end
            end
            default: begin
            end
          endcase
        end else if (iss_r == cnt_r) begin
          unique case (kind_r)
            KIND_ALLOC: begin
              if (found_r) begin
                state_nxt = S_CHK;
              end else begin
                res_status_nxt = ST_NO_FIT;
                state_nxt      = S_DONE;
              end
            end
            KIND_FREE: begin
              if (found_r) begin
                state_nxt = S_RELEASE;
              end else begin
                res_status_nxt = ST_NOT_FOUND;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              res_size_nxt = acc_r;
              state_nxt    = S_DONE;
            end
          endcase
        end
      end

      S_CHK: begin
        split_nxt = (SW'(best_size_r) > split_sum) && (cnt_r < CNT_W'(SLOT_COUNT));
        state_nxt = S_TAIL;
      end

      S_TAIL: begin
        if (split_r) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = cnt_r[IDX_W-1:0];
          tbl_wr_data = {1'b0, OWNER_W'(0), SZ_W'(tail_size_dif), OFF_W'(tail_off_sum)};
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        state_nxt = S_GRANT;
      end

      S_GRANT: begin
        tbl_wr_en    = 1'b1;
        tbl_wr_addr  = best_idx_r;
        tbl_wr_data  = {1'b1, own_r, grant_size, best_off_r};
        free_nxt     = free_r - grant_size;
        res_off_nxt  = best_off_r;
        res_size_nxt = grant_size;
        state_nxt    = S_DONE;
      end

      S_RELEASE: begin
        tbl_wr_en    = 1'b1;
        tbl_wr_addr  = best_idx_r;
        tbl_wr_data  = {1'b0, best_own_r, best_size_r, best_off_r};
        free_nxt     = free_r + best_size_r;
        res_size_nxt = best_size_r;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_offset_nxt = RES_OFF_W'(res_off_r);
          out_size_nxt   = RES_SIZE_W'(res_size_r);
          out_free_nxt   = RES_SIZE_W'(free_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/best_fit_block_allocator.sv =====
// Best-fit block allocator over one pool, kept as a table of blocks.
// Input channel (in_valid/in_ready): one request per transfer, kind selects
// allocate, free by offset or free all blocks of an owner.
// Output channel (out_valid/out_ready): one result per request with status,
// granted or released size and the bytes still free in the pool.
// cfg_wr_en/cfg_wr_data write the split threshold; write only while idle.
// Each request walks the block table through one read port, one entry per
// cycle; free-all and searches that find nothing answer when the walk ends,
// a free adds a release step and a granted allocate adds check, tail and
// grant steps; a zero-size allocate or an unused kind skips the walk and
// answers directly. The walk covers every block in the table.
// One request is in flight at a time; in_ready is high only while idle, and
// rises in the same cycle as each result is issued.
// The result sits in an output register: a stalled receiver holds it, and a
// further request is taken meanwhile but its result waits until the first
// one is transferred.
// After reset the table is set to a single free block holding the whole
// pool in an init state, before the first request is taken.
`default_nettype none

module best_fit_block_allocator #(
  parameter int POOL_BYTES = bfa_pkg::POOL_BYTES_DEF,
  parameter int SLOT_COUNT = bfa_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bfa_pkg::MS_W-1:0]         cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bfa_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [bfa_pkg::REQ_W-1:0]        in_request_size,
  input  wire logic [bfa_pkg::BOFF_W-1:0]       in_block_offset,
  input  wire logic [bfa_pkg::OWNER_W-1:0]      in_owner,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bfa_pkg::STATUS_W-1:0]          out_status,
  output logic [bfa_pkg::RES_OFF_W-1:0]         out_offset,
  output logic [bfa_pkg::RES_SIZE_W-1:0]        out_block_size,
  output logic [bfa_pkg::RES_SIZE_W-1:0]        out_free_left
);

  import bfa_pkg::*;

  localparam int SZ_W  = $clog2(POOL_BYTES + 1);
  localparam int OFF_W = $clog2(POOL_BYTES);
  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int ENT_W = 1 + OWNER_W + SZ_W + OFF_W;

  logic [MS_W-1:0] min_split_r;

  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  logic [ENT_W-1:0] tbl_wr_data;
  logic [IDX_W-1:0] tbl_rd_addr;
  logic [ENT_W-1:0] tbl_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_split_r <= MIN_SPLIT_RST;
    end else if (cfg_wr_en) begin
      min_split_r <= cfg_wr_data;
    end
  end

  bfa_table #(
    .DEPTH (SLOT_COUNT),
    .ENT_W (ENT_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  bfa_ctrl #(
    .POOL_BYTES (POOL_BYTES),
    .SLOT_COUNT (SLOT_COUNT),
    .ENT_W      (ENT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .min_split       (min_split_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_request_size (in_request_size),
    .in_block_offset (in_block_offset),
    .in_owner        (in_owner),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_offset      (out_offset),
    .out_block_size  (out_block_size),
    .out_free_left   (out_free_left),
    .tbl_wr_en       (tbl_wr_en),
    .tbl_wr_addr     (tbl_wr_addr),
    .tbl_wr_data     (tbl_wr_data),
    .tbl_rd_addr     (tbl_rd_addr),
    .tbl_rd_data     (tbl_rd_data)
  );

endmodule

`default_nettype wire

// ===== verif/tb_best_fit_block_allocator.sv =====
`timescale 1ns / 100ps

module tb_best_fit_block_allocator;
  import bfa_pkg::*;

  localparam int POOL        = POOL_BYTES_DEF;
  localparam int BLOCKS      = SLOT_COUNT_DEF;
  localparam int IDLE_PCT    = 8;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 50;
  localparam int PHASE_ITEMS = 195;
  localparam int LIMIT       = 400000;

  typedef enum logic [1:0] {
    PICK_NONE,
    PICK_USED,
    PICK_ANY
  } offset_pick_t;

  typedef struct {
    kind_t               kind;
    logic [REQ_W-1:0]    size;
    logic [BOFF_W-1:0]   boff;
    logic [OWNER_W-1:0]  owner;
    offset_pick_t        pick;
  } pool_req_t;

  typedef struct {
    status_t               status;
    logic [RES_OFF_W-1:0]  offset;
    logic [RES_SIZE_W-1:0] block_size;
    logic [RES_SIZE_W-1:0] free_left;
  } pool_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [MS_W-1:0]       cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [REQ_W-1:0]      in_request_size = '0;
  logic [BOFF_W-1:0]     in_block_offset = '0;
  logic [OWNER_W-1:0]    in_owner = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [RES_OFF_W-1:0]  out_offset;
  logic [RES_SIZE_W-1:0] out_block_size;
  logic [RES_SIZE_W-1:0] out_free_left;

  // pool table as the predictor sees it
  int unsigned blk_off [BLOCKS];
  int unsigned blk_size [BLOCKS];
  int unsigned blk_owner [BLOCKS];
  bit          blk_used [BLOCKS];
  int          blk_count = 1;
  int          blk_peak = 1;
  int unsigned pool_free = POOL;
  int unsigned split_min = 16;

  pool_req_t    pending_q [$];
  pool_result_t result_q [$];
  pool_req_t    cur_req;

  bit no_idle = 1'b0;
  int n_sent = 0;
  int n_checked = 0;
  int n_err = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cyc = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  best_fit_block_allocator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_request_size (in_request_size),
    .in_block_offset (in_block_offset),
    .in_owner        (in_owner),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_offset      (out_offset),
    .out_block_size  (out_block_size),
    .out_free_left   (out_free_left)
  );

  always #10 clk = ~clk;

  function automatic pool_result_t pool_apply(input pool_req_t r);
    pool_result_t res;
    int unsigned  need;
    int unsigned  best_sz;
    int unsigned  own;
    int unsigned  released;
    int           best;
    bit           found;
    res.status = ST_OK;
    res.offset = '0;
    res.block_size = '0;
    own = r.owner % MAX_OWNERS;
    need = 0;
    best = 0;
    best_sz = 0;
    found = 1'b0;
    released = 0;
    case (r.kind)
      KIND_ALLOC: begin
        if (r.size == '0) begin
          res.status = ST_ZERO;
        end else begin
          need = ((int'(r.size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
          for (int i = 0; i < blk_count; i++) begin
            if (!blk_used[i] && blk_size[i] >= need && (!found || blk_size[i] < best_sz)) begin
              found = 1'b1;
              best = i;
              best_sz = blk_size[i];
            end
          end
          if (!found) begin
            res.status = ST_NO_FIT;
          end else begin
            // tail becomes a new free block
            if (blk_size[best] > need + split_min && blk_count < BLOCKS) begin
              blk_off[blk_count] = blk_off[best] + need;
              blk_size[blk_count] = blk_size[best] - need;
              blk_owner[blk_count] = 0;
              blk_used[blk_count] = 1'b0;
              blk_size[best] = need;
              blk_count++;
            end
            blk_used[best] = 1'b1;
            blk_owner[best] = own;
            pool_free -= blk_size[best];
            res.offset = RES_OFF_W'(blk_off[best]);
            res.block_size = RES_SIZE_W'(blk_size[best]);
          end
        end
      end
      KIND_FREE: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < blk_count && res.status == ST_NOT_FOUND; i++) begin
          if (blk_used[i] && blk_off[i] == r.boff) begin
            blk_used[i] = 1'b0;
            pool_free += blk_size[i];
            res.block_size = RES_SIZE_W'(blk_size[i]);
            res.status = ST_OK;
          end
        end
      end
      KIND_FREE_ALL: begin
        for (int i = 0; i < blk_count; i++) begin
          if (blk_used[i] && blk_owner[i] == own) begin
            blk_used[i] = 1'b0;
            pool_free += blk_size[i];
            released += blk_size[i];
          end
        end
        res.block_size = RES_SIZE_W'(released);
      end
      default: begin
      end
    endcase
    res.free_left = RES_SIZE_W'(pool_free);
    if (blk_count > blk_peak) begin
      blk_peak = blk_count;
    end
    return res;
  endfunction

  // free targets are chosen from the table as it stands when the request goes out
  function automatic pool_req_t pick_offset(input pool_req_t r);
    int live [$];
    if (r.pick == PICK_USED) begin
      for (int i = 0; i < blk_count; i++) begin
        if (blk_used[i]) begin
          live.push_back(i);
        end
      end
      if (live.size() != 0) begin
        r.boff = BOFF_W'(blk_off[live[$urandom_range(live.size() - 1)]]);
      end
    end else if (r.pick == PICK_ANY) begin
      r.boff = BOFF_W'(blk_off[$urandom_range(blk_count - 1)]);
    end
    return r;
  endfunction

  function automatic pool_req_t make_request();
    pool_req_t   r;
    int unsigned roll;
    int unsigned sel;
    roll = $urandom_range(99);
    sel = $urandom_range(9);
    r.kind = KIND_ALLOC;
    r.size = REQ_W'($urandom_range(POOL));
    r.boff = BOFF_W'($urandom);
    r.owner = OWNER_W'($urandom);
    r.pick = PICK_NONE;
    if (roll < 45) begin
      if (sel < 6) begin
        r.size = REQ_W'($urandom_range(512, 1));
      end else if (sel < 9) begin
        r.size = REQ_W'($urandom_range(4096, 1));
      end else begin
        r.size = REQ_W'($urandom_range(POOL, 4097));
      end
    end else if (roll < 73) begin
      r.kind = KIND_FREE;
      r.pick = PICK_USED;
    end else if (roll < 81) begin
      r.kind = KIND_FREE_ALL;
    end else if (roll < 88) begin
      r.kind = KIND_FREE;
      r.pick = $urandom_range(1) ? PICK_ANY : PICK_NONE;
    end else if (roll < 94) begin
      r.size = $urandom_range(1) ? REQ_W'(0) : REQ_W'($urandom_range(POOL, POOL - 8));
    end else begin
      r.kind = KIND_NONE;
    end
    return r;
  endfunction

  task automatic queue_req(input kind_t kind, input int unsigned size, input int unsigned boff,
                           input int unsigned owner);
    pool_req_t r;
    r.kind = kind;
    r.size = REQ_W'(size);
    r.boff = BOFF_W'(boff);
    r.owner = OWNER_W'(owner);
    r.pick = PICK_NONE;
    pending_q.push_back(r);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      pending_q.push_back(make_request());
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || result_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_split(input int unsigned value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= MS_W'(value);
    split_min = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk) begin : drive
    pool_req_t    nxt;
    pool_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        res = pool_apply(cur_req);
        result_q.push_back(res);
        n_sent <= n_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pick_offset(pending_q.pop_front());
          cur_req = nxt;
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_request_size <= nxt.size;
          in_block_offset <= nxt.boff;
          in_owner <= nxt.owner;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up onto its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : observe
    pool_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result transfer with none expected, status %0d offset %0d size %0d",
                   $time, out_status, out_offset, out_block_size);
          n_err++;
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("offset", want.offset, out_offset);
          check_field("block_size", want.block_size, out_block_size);
          check_field("free_left", want.free_left, out_free_left);
        end
        status_seen[out_status]++;
        n_checked <= n_checked + 1;
      end
      out_ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, result_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    blk_size[0] = POOL;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_req(KIND_ALLOC, 0, 0, 0);
    queue_req(KIND_ALLOC, POOL, 0, 15);
    queue_req(KIND_ALLOC, 1, 0, 1);
    queue_req(KIND_FREE, 0, 0, 0);
    queue_req(KIND_FREE, 0, 0, 0);
    queue_req(KIND_NONE, POOL, 16'hffff, 15);
    queue_req(KIND_ALLOC, 1, 0, 3);
    queue_req(KIND_ALLOC, 8, 0, 4);
    queue_req(KIND_ALLOC, 7, 0, 4);
    queue_req(KIND_FREE, 0, 0, 0);
    queue_req(KIND_FREE, 0, 16, 0);
    queue_req(KIND_ALLOC, 3, 0, 9);
    queue_req(KIND_FREE_ALL, 0, 0, 4);
    queue_req(KIND_FREE_ALL, 0, 0, 12);
    queue_req(KIND_ALLOC, 65513, 0, 2);
    queue_req(KIND_ALLOC, 65505, 0, 6);
    queue_req(KIND_FREE, 0, 24, 0);
    queue_req(KIND_ALLOC, 65480, 0, 0);
    queue_req(KIND_ALLOC, 17, 0, 11);
    queue_req(KIND_FREE_ALL, 0, 0, 0);
    queue_req(KIND_FREE, 0, 16'hffff, 0);
    queue_req(KIND_FREE, 0, 65504, 0);
    queue_req(KIND_NONE, 0, 0, 0);
    wait_drained();

    no_idle = 1'b1;
    set_split(POOL);
    queue_random(PHASE_ITEMS);
    wait_drained();
    no_idle = 1'b0;

    set_split($urandom_range(8192, 64));
    queue_random(PHASE_ITEMS);
    wait_drained();

    set_split(0);
    queue_random(PHASE_ITEMS);
    wait_drained();

    set_split($urandom_range(POOL));
    queue_random(PHASE_ITEMS);
    wait_drained();

    $display("covered %0d requests under five split thresholds, %0d results compared",
             n_sent, n_checked);
    $display("status mix ok %0d zero %0d no-fit %0d not-found %0d, table peak %0d blocks",
             status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_NO_FIT],
             status_seen[ST_NOT_FOUND], blk_peak);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
